[hw/rtl/cbd_pkg.sv]
`timescale 1ns / 1ps

package cbd_pkg;

  // Default largest stride the sample chain is built for
  localparam int MAX_STRIDE_DEF = 64;

  // Payload and register widths
  localparam int SAMPLE_W = 16;
  localparam int STRIDE_W = 7;
  localparam int CFG_DW   = 32;
  localparam int ADDR_W   = 3;

  // Register word index (byte address bits above the word offset)
  localparam logic [ADDR_W-3:0] REG_STRIDE = '0;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1);

  // Operation broadcast along the sample chain
  typedef struct packed {
    logic fill;   // load every cell with the new sample
    logic push;   // shift the window by one sample
  } chain_op_t;

endpackage

[hw/rtl/cbd_cell.sv]
`timescale 1ns / 1ps

module cbd_cell #(
  parameter int IDX = 0,
  parameter int EW  = 7
) (
  input  logic                          clk,
  input  cbd_pkg::chain_op_t            op,
  input  logic [cbd_pkg::SAMPLE_W-1:0]  x,
  input  logic [cbd_pkg::SAMPLE_W-1:0]  prev,
  input  logic [EW-1:0]                 entry,
  output logic [cbd_pkg::SAMPLE_W-1:0]  data
);

  localparam logic [EW-1:0] POS = EW'(IDX);

  logic [cbd_pkg::SAMPLE_W-1:0] data_r;

  // Cells from the entry point onward take part in the window; the entry
  // cell takes the new sample, the rest take their left neighbour's value.
  always_ff @(posedge clk) begin
    if (op.fill) begin
      data_r <= x;
    end else if (op.push && (POS >= entry)) begin
      data_r <= (POS == entry) ? x : prev;
    end
  end

  assign data = data_r;

endmodule

[hw/rtl/cbd_chain.sv]
`timescale 1ns / 1ps

module cbd_chain #(
  parameter int DEPTH = 127,
  parameter int EW    = 7
) (
  input  logic                          clk,
  input  cbd_pkg::chain_op_t            op,
  input  logic [cbd_pkg::SAMPLE_W-1:0]  x,
  input  logic [EW-1:0]                 entry,
  output logic [cbd_pkg::SAMPLE_W-1:0]  oldest
);

  logic [cbd_pkg::SAMPLE_W-1:0] cell_q [DEPTH];

  // Row of cells; the oldest sample of the window always sits in the last
  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
        cbd_cell #(.IDX(k), .EW(EW)) u_cell (
          .clk   (clk),
          .op    (op),
          .x     (x),
          .prev  (x),
          .entry (entry),
          .data  (cell_q[k])
        );
      end else begin : g_rest
        cbd_cell #(.IDX(k), .EW(EW)) u_cell (
          .clk   (clk),
          .op    (op),
          .x     (x),
          .prev  (cell_q[k-1]),
          .entry (entry),
          .data  (cell_q[k])
        );
      end
    end
  endgenerate

  assign oldest = cell_q[DEPTH-1];

endmodule

[hw/rtl/cbd_div.sv]
`timescale 1ns / 1ps

module cbd_div #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // One restoring step: bring down the next dividend bit, try the subtract
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r <= dividend;
        rem_r <= '0;
        cnt_r <= CW'(NW);
      end else if (cnt_r != '0) begin
        num_r <= {num_r[NW-2:0], ge};
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

[hw/rtl/centered_boxcar_decimator.sv]
`timescale 1ns / 1ps

// Centred boxcar decimator. Every stride-th sample (and the sample flagged
// last) yields the rounded-half-up mean of the 2*stride-1 samples centred
// on the kept index. Such a request keeps in_ready low until its result
// enters the output register: on the last sample first while the right edge
// of the window is padded with copies of it, then while the bit-per-cycle
// divider runs. Samples that keep no result leave in_ready high. The window
// lives in a row of 2*MAX_STRIDE-1 cells; a capture's first sample fills
// them all, giving the left-edge padding. A finished result sits in an
// output register, so the next sample can be taken while it waits. Writing
// the stride register (byte address 0, 0 acts as 1, values above MAX_STRIDE
// saturate) abandons any capture in progress.
module centered_boxcar_decimator #(
  parameter int MAX_STRIDE = cbd_pkg::MAX_STRIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_last,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbd_pkg::SAMPLE_W-1:0]  out_average,
  output logic                          out_final_res,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbd_pkg::ADDR_W-1:0]    paddr,
  input  logic [cbd_pkg::CFG_DW-1:0]    pwdata,
  output logic [cbd_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int SW    = $clog2(MAX_STRIDE + 1);
  localparam int WW    = $clog2(2 * MAX_STRIDE);
  localparam int DEPTH = 2 * MAX_STRIDE - 1;
  localparam int SUMW  = cbd_pkg::SAMPLE_W + WW;
  localparam int NW    = SUMW + 1;
  localparam int DW    = WW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_t;

  state_t                          state_r;
  logic [cbd_pkg::STRIDE_W-1:0]    stride_r;
  logic [SW-1:0]                   s_r;
  logic [WW-1:0]                   w_r;
  logic [WW-1:0]                   entry_r;
  logic                            started_r;
  logic [SW-1:0]                   phase_r;
  logic [SW-1:0]                   pad_r;
  logic [SUMW-1:0]                 sum_r;
  logic [cbd_pkg::SAMPLE_W-1:0]    x_r;
  logic                            fin_r;
  logic                            out_valid_r;
  logic [cbd_pkg::SAMPLE_W-1:0]    out_average_r;
  logic                            out_final_r;

  logic                            in_acc;
  logic                            reg_sel;
  logic                            cfg_wr;
  logic [SW-1:0]                   s_nxt;
  logic [WW-1:0]                   w_nxt;
  logic [SW:0]                     phase_inc;
  logic [SW-1:0]                   phase_nxt;
  logic                            kept;
  logic [SW-1:0]                   pad_cnt;
  logic [cbd_pkg::SAMPLE_W-1:0]    push_x;
  logic [cbd_pkg::SAMPLE_W-1:0]    oldest;
  logic [SUMW-1:0]                 push_sum;
  logic [SUMW-1:0]                 fill_sum;
  cbd_pkg::chain_op_t              op;
  logic                            div_done;
  logic [NW-1:0]                   quotient;
  logic [NW-1:0]                   dividend;

  assign in_acc = in_valid && in_ready;

  // Register port: one word, always ready
  assign reg_sel = paddr[cbd_pkg::ADDR_W-1:2] == cbd_pkg::REG_STRIDE;
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? cbd_pkg::CFG_DW'(stride_r) : '0;

  // Effective stride and window length, settled when the register is written
  always_comb begin
    if (pwdata[cbd_pkg::STRIDE_W-1:0] == '0) begin
      s_nxt = SW'(1);
    end else if (int'(pwdata[cbd_pkg::STRIDE_W-1:0]) > MAX_STRIDE) begin
      s_nxt = SW'(MAX_STRIDE);
    end else begin
      s_nxt = SW'(pwdata[cbd_pkg::STRIDE_W-1:0]);
    end
    w_nxt = WW'((32'(s_nxt) << 1) - 32'd1);
  end

  // Phase bookkeeping for an accepted sample
  assign phase_inc = {1'b0, phase_r} + (SW+1)'(1);
  assign phase_nxt = !started_r ? '0 :
                     (phase_inc >= {1'b0, s_r}) ? '0 : phase_inc[SW-1:0];
  assign kept      = phase_nxt == (s_r - SW'(1));
  assign pad_cnt   = s_r - SW'(1) - phase_nxt;

  // Window update: drop the oldest sample, add the new one
  assign push_x   = (state_r == ST_PAD) ? x_r : in_sample;
  assign push_sum = sum_r - SUMW'(oldest) + SUMW'(push_x);
  assign fill_sum = SUMW'(in_sample) * SUMW'(w_r);

  // fill in the upper bit, push in the lower
  assign op = {in_acc && !started_r, (in_acc && started_r) || (state_r == ST_PAD)};

  cbd_chain #(.DEPTH(DEPTH), .EW(WW)) u_chain (
    .clk    (clk),
    .op     (op),
    .x      (push_x),
    .entry  (entry_r),
    .oldest (oldest)
  );

  // Rounded mean: (2*sum + w) / (2*w)
  assign dividend = {sum_r, 1'b0} + NW'(w_r);

  cbd_div #(.NW(NW), .DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .dividend (dividend),
    .divisor  ({w_r, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stride_r    <= cbd_pkg::STRIDE_RESET;
      s_r         <= SW'(1);
      w_r         <= WW'(1);
      entry_r     <= WW'(DEPTH - 1);
      started_r   <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Output valid: set on a finished average, cleared once taken
      if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            x_r       <= in_sample;
            fin_r     <= in_last;
            phase_r   <= phase_nxt;
            sum_r     <= started_r ? push_sum : fill_sum;
            started_r <= !in_last;
            pad_r     <= pad_cnt;
            if (in_last) begin
              state_r <= (pad_cnt != '0) ? ST_PAD : ST_START;
            end else if (kept) begin
              state_r <= ST_START;
            end
          end
        end
        ST_PAD: begin
          sum_r <= push_sum;
          pad_r <= pad_r - SW'(1);
          if (pad_r == SW'(1)) begin
            state_r <= ST_START;
          end
        end
        ST_START: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_average_r <= quotient[cbd_pkg::SAMPLE_W-1:0];
            out_final_r   <= fin_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // A stride write abandons the capture in progress
      if (cfg_wr) begin
        stride_r  <= pwdata[cbd_pkg::STRIDE_W-1:0];
        s_r       <= s_nxt;
        w_r       <= w_nxt;
        entry_r   <= WW'(DEPTH) - w_nxt;
        started_r <= 1'b0;
        phase_r   <= '0;
      end
    end
  end

  assign in_ready      = state_r == ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_final_res = out_final_r;

endmodule

[hw/rtl/cbd_checker.sv]
`timescale 1ns / 1ps

module cbd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cbd_pkg::SAMPLE_W-1:0]  out_average,
  input logic                          out_final_res
);

  // A waiting result holds still until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_final_res))
    else $error("result changed or vanished while stalled");

  // The last sample always produces a result, so the block goes busy
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready)
    else $error("sample request taken while final average still pending");

  // A fresh result only appears after a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a division pass");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind centered_boxcar_decimator cbd_checker u_cbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_average   (out_average),
  .out_final_res (out_final_res)
);
